### rtl/mfd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the marker length table for the marker frame deframer
package mfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 5;

    localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hA5;
    localparam logic [IDX_W-1:0]  SYNC_LEN      = 5'd21;
    localparam logic [BYTE_W-1:0] SYNC_GAP_RST  = 8'd22;
    localparam logic [BYTE_W-1:0] HUNT_MAX      = 8'hFF;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_MARKER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CHECK   = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [BYTE_W-1:0]  hunt_count;
        logic [BYTE_W-1:0]  current_marker;
        logic [IDX_W-1:0]   bytes_left;
        logic [IDX_W-1:0]   payload_position;
        logic [BYTE_W-1:0]  running_sum;
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0]  marker_code;
        logic [IDX_W-1:0]   byte_index;
        logic [BYTE_W-1:0]  data_byte;
        logic               is_payload;
        logic               frame_end;
        logic               frame_ok;
        logic               request_transfer_mode;
    } t_result;

    // payload length per marker, zero for an unknown marker
    function automatic logic [IDX_W-1:0] marker_len(input logic [BYTE_W-1:0] code);
        logic [IDX_W-1:0] len;
        unique case (code)
            8'hA5:   len = 5'd21;
            8'hAF:   len = 5'd16;
            8'hAE:   len = 5'd8;
            8'hA0:   len = 5'd4;
            8'hA1:   len = 5'd25;
            8'hAD:   len = 5'd4;
            8'hAA:   len = 5'd2;
            8'hA2:   len = 5'd2;
            8'hA7:   len = 5'd1;
            8'hA4:   len = 5'd4;
            8'hA6:   len = 5'd4;
            8'h75:   len = 5'd6;
            8'h76:   len = 5'd2;
            8'h77:   len = 5'd2;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

### rtl/mfd_step.sv
`timescale 1ns / 1ps
// per-byte framing step: next state and result for one received byte
module mfd_step (
    input  mfd_pkg::t_state               i_state,
    input  logic [mfd_pkg::BYTE_W-1:0]    i_byte,
    input  logic [mfd_pkg::BYTE_W-1:0]    i_sync_gap,
    output mfd_pkg::t_state               o_state,
    output logic                          o_res_valid,
    output mfd_pkg::t_result              o_res
);
    import mfd_pkg::*;

    logic             w_is_sync;
    logic             w_gap_match;
    logic [IDX_W-1:0] w_len;

    assign w_is_sync   = (i_byte == SYNC_BYTE);
    assign w_gap_match = (i_state.hunt_count == i_sync_gap);
    assign w_len       = marker_len(i_byte);

    // next state
    always_comb begin
        o_state = i_state;
        unique case (i_state.phase)
            PH_HUNT: begin
                if (!w_is_sync) begin
                    if (i_state.hunt_count != HUNT_MAX) begin
                        o_state.hunt_count = i_state.hunt_count + 8'd1;
                    end
                end else if (w_gap_match) begin
                    o_state.hunt_count       = '0;
                    o_state.current_marker   = SYNC_BYTE;
                    o_state.bytes_left       = SYNC_LEN;
                    o_state.payload_position = '0;
                    o_state.running_sum      = '0;
                    o_state.phase            = PH_PAYLOAD;
                end else begin
                    o_state.hunt_count = '0;
                end
            end
            PH_MARKER: begin
                if (w_len == '0) begin
                    o_state.phase      = PH_HUNT;
                    o_state.hunt_count = '0;
                end else begin
                    o_state.current_marker   = i_byte;
                    o_state.bytes_left       = w_len;
                    o_state.payload_position = '0;
                    o_state.running_sum      = '0;
                    o_state.phase            = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                o_state.running_sum      = i_state.running_sum + i_byte;
                o_state.payload_position = i_state.payload_position + 5'd1;
                if (i_state.bytes_left <= 5'd1) begin
                    o_state.bytes_left = '0;
                    o_state.phase      = PH_CHECK;
                end else begin
                    o_state.bytes_left = i_state.bytes_left - 5'd1;
                end
            end
            PH_CHECK: begin
                o_state.phase = PH_MARKER;
            end
            default: begin
                o_state.phase = PH_HUNT;
            end
        endcase
    end

    // result
    always_comb begin
        o_res       = '0;
        o_res_valid = 1'b0;
        unique case (i_state.phase)
            PH_HUNT: begin
                if (w_is_sync && !w_gap_match) begin
                    o_res_valid                 = 1'b1;
                    o_res.request_transfer_mode = 1'b1;
                end
            end
            PH_MARKER: begin
                o_res_valid = 1'b0;
            end
            PH_PAYLOAD: begin
                o_res_valid       = 1'b1;
                o_res.marker_code = i_state.current_marker;
                o_res.byte_index  = i_state.payload_position;
                o_res.data_byte   = i_byte;
                o_res.is_payload  = 1'b1;
            end
            PH_CHECK: begin
                o_res_valid       = 1'b1;
                o_res.marker_code = i_state.current_marker;
                o_res.data_byte   = i_byte;
                o_res.frame_end   = 1'b1;
                o_res.frame_ok    = (i_state.running_sum == i_byte);
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

endmodule

### rtl/marker_frame_deframer_top.sv
`timescale 1ns / 1ps
// top level of the marker frame deframer: handshakes, state and result registers
// a result is registered: it appears in the cycle after the request that causes it is accepted
// throughput: one byte per cycle; the only limit is the single result register
// a byte is taken while a result waits, as long as that result leaves in the same cycle
// reset (synchronous, active low): hunt phase, all counters zero, sync_gap back to 22
// marker, payload, check and hunt bytes each take one pass through mfd_step
module marker_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: sync_gap
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    // received byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_marker_code,
    output logic [4:0]  o_byte_index,
    output logic [7:0]  o_data_byte,
    output logic        o_is_payload,
    output logic        o_frame_end,
    output logic        o_frame_ok,
    output logic        o_request_transfer_mode
);
    import mfd_pkg::*;

    // framing state and the sync gap register
    t_state            r_state;
    t_state            n_state;
    logic [BYTE_W-1:0] r_sync_gap;

    // result register
    t_result           r_out;
    logic              r_out_valid;
    logic              n_out_valid;

    // step outputs
    t_state            w_step_state;
    t_result           w_step_res;
    logic              w_step_valid;

    logic              w_in_accept;

    // hold input only while a result waits and downstream also holds it
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_in_accept = i_in_valid & ~o_in_stall;

    mfd_step u_step (
        .i_state     (r_state),
        .i_byte      (i_rx_byte),
        .i_sync_gap  (r_sync_gap),
        .o_state     (w_step_state),
        .o_res_valid (w_step_valid),
        .o_res       (w_step_res)
    );

    // state only advances on an accepted request
    assign n_state = w_in_accept ? w_step_state : r_state;

    // keep a stalled result, else load a new one if this request makes one
    assign n_out_valid = (r_out_valid & i_out_stall) | (w_in_accept & w_step_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase            <= PH_HUNT;
            r_state.hunt_count       <= '0;
            r_state.current_marker   <= '0;
            r_state.bytes_left       <= '0;
            r_state.payload_position <= '0;
            r_state.running_sum      <= '0;
            r_sync_gap               <= SYNC_GAP_RST;
            r_out_valid              <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_sync_gap <= i_cfg_data;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_accept && w_step_valid) begin
            r_out <= w_step_res;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_marker_code           = r_out.marker_code;
    assign o_byte_index            = r_out.byte_index;
    assign o_data_byte             = r_out.data_byte;
    assign o_is_payload            = r_out.is_payload;
    assign o_frame_end             = r_out.frame_end;
    assign o_frame_ok              = r_out.frame_ok;
    assign o_request_transfer_mode = r_out.request_transfer_mode;

endmodule
